FILE: src/ordered_key_set_pred_succ_defines.svh
// Assertion macros for the ordered key set block.
// Used by files that carry concurrent checks; depends on nothing else.
`ifndef ORDERED_KEY_SET_PRED_SUCC_DEFINES_SVH
`define ORDERED_KEY_SET_PRED_SUCC_DEFINES_SVH

`ifndef SYNTH
`define OKSPD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define OKSPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OKSPD_ASSERT(lbl, clk, rstn, prop, msg)
`define OKSPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: src/okspd_pkg.sv
// Shared types, constants and bit-scan functions for the ordered key set.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
package okspd_pkg;

  localparam int DEF_KEY_BITS   = 10;
  localparam int DEF_VALUE_BITS = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_DELETE = 3'd2,
    OP_PRED   = 3'd3,
    OP_SUCC   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_SUMK,
    ST_SUM,
    ST_WRD,
    ST_VAL,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SCAN_BELOW,
    SCAN_ABOVE,
    SCAN_TOP,
    SCAN_LOW
  } scan_mode_t;

  typedef struct packed {
    logic pw_we;
    logic pw_re;
    logic sw_we;
    logic sw_re;
    logic val_we;
    logic val_re;
  } mem_ctl_t;

  // Address width of the presence word store.
  function automatic int word_idx_bits(input int kb);
    return (kb > 5) ? kb - 5 : 1;
  endfunction

  // Address width of the summary word store.
  function automatic int sum_idx_bits(input int kb);
    return (kb > 10) ? kb - 10 : 1;
  endfunction

  function automatic int num_words(input int kb);
    return (kb > 5) ? (1 << (kb - 5)) : 1;
  endfunction

  function automatic int num_sum_words(input int kb);
    return (kb > 10) ? (1 << (kb - 10)) : 1;
  endfunction

  // Index of the single set bit of a one-hot word.
  function automatic logic [4:0] onehot_enc(input logic [31:0] oh);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (oh[i]) begin
        r = r | 5'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [4:0] low_bit(input logic [31:0] m);
    logic [31:0] iso;
    iso = m & (~m + 32'd1);
    return onehot_enc(iso);
  endfunction

  function automatic logic [4:0] top_bit(input logic [31:0] m);
    logic [31:0] rev;
    logic [31:0] iso;
    for (int i = 0; i < 32; i++) begin
      rev[i] = m[31 - i];
    end
    iso = rev & (~rev + 32'd1);
    return 5'd31 - onehot_enc(iso);
  endfunction

endpackage

FILE: src/okspd_scan.sv
// Shared word scan unit: finds the nearest set bit of a 32-bit bitmap word
// around a position, or its highest or lowest set bit. Depends on okspd_pkg.
`timescale 1ns / 1ps
module okspd_scan (
  input  logic [31:0]             word,
  input  logic [4:0]              pos,
  input  okspd_pkg::scan_mode_t   mode,
  output logic                    hit,
  output logic [4:0]              idx
);
  import okspd_pkg::*;

  logic [31:0] mask;
  logic [31:0] masked;
  logic        use_top;

  always_comb begin
    case (mode)
      SCAN_BELOW: mask = ~(32'hFFFF_FFFF << pos);
      SCAN_ABOVE: mask = 32'hFFFF_FFFE << pos;
      default:    mask = 32'hFFFF_FFFF;
    endcase
  end

  assign use_top = (mode == SCAN_BELOW) || (mode == SCAN_TOP);
  assign masked  = word & mask;
  assign hit     = |masked;
  assign idx     = use_top ? top_bit(masked) : low_bit(masked);

endmodule

FILE: src/okspd_store.sv
// Presence words, summary words and stored values, each a single-port
// memory with registered read data. Depends on okspd_pkg.
`timescale 1ns / 1ps
module okspd_store #(
  parameter int KEY_BITS   = okspd_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = okspd_pkg::DEF_VALUE_BITS
) (
  input  logic                                     clk,
  input  okspd_pkg::mem_ctl_t                      ctl,
  input  logic [okspd_pkg::word_idx_bits(KEY_BITS)-1:0] pw_addr,
  input  logic [31:0]                              pw_wdata,
  output logic [31:0]                              pw_rdata,
  input  logic [okspd_pkg::sum_idx_bits(KEY_BITS)-1:0]  sw_addr,
  input  logic [31:0]                              sw_wdata,
  output logic [31:0]                              sw_rdata,
  input  logic [KEY_BITS-1:0]                      val_addr,
  input  logic [VALUE_BITS-1:0]                    val_wdata,
  output logic [VALUE_BITS-1:0]                    val_rdata
);
  import okspd_pkg::*;

  localparam int NUM_KEYS  = 1 << KEY_BITS;
  localparam int NUM_WORDS = num_words(KEY_BITS);
  localparam int NUM_SUMS  = num_sum_words(KEY_BITS);

  logic [31:0]           pw_mem  [NUM_WORDS];
  logic [31:0]           sw_mem  [NUM_SUMS];
  logic [VALUE_BITS-1:0] val_mem [NUM_KEYS];

  logic [31:0]           pw_rdata_r;
  logic [31:0]           sw_rdata_r;
  logic [VALUE_BITS-1:0] val_rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.pw_we) begin
      pw_mem[pw_addr] <= pw_wdata;
    end
    if (ctl.pw_re) begin
      pw_rdata_r <= pw_mem[pw_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sw_we) begin
      sw_mem[sw_addr] <= sw_wdata;
    end
    if (ctl.sw_re) begin
      sw_rdata_r <= sw_mem[sw_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.val_we) begin
      val_mem[val_addr] <= val_wdata;
    end
    if (ctl.val_re) begin
      val_rdata_r <= val_mem[val_addr];
    end
  end

  assign pw_rdata  = pw_rdata_r;
  assign sw_rdata  = sw_rdata_r;
  assign val_rdata = val_rdata_r;

endmodule

FILE: src/ordered_key_set_pred_succ.sv
// Top level of the ordered key set: sequencer, result register and ports.
// Depends on okspd_pkg, okspd_scan, okspd_store and the assertion macros.
`timescale 1ns / 1ps
`include "ordered_key_set_pred_succ_defines.svh"
// The block holds a set of keys from 0 to 2**KEY_BITS-1, each with a stored
// value, and answers one item at a time: insert or replace, lookup, delete,
// predecessor (greatest present key strictly below) and successor (least
// present key strictly above). Every item gives exactly one result item.
// Presence is a two-level bitmap, one bit per key in 32-bit presence words
// and one bit per nonzero presence word in summary words, held in memories
// with registered reads, and one scan unit finds the nearest set bit of a
// word under a small sequencer. While an item is at work in_stall is high.
// Insert, lookup, delete and unused op codes go through a read, an update
// and a hand-off before the next item can be accepted. A predecessor or
// successor found in the key's own presence word adds a read of its value;
// one that has to go through the summary also scans the key's summary word
// and reads the presence word it points to, plus one more summary read for
// each further summary word stepped over (none at KEY_BITS of 10 or less),
// and a search that finds no neighbor ends after the summary scan and the
// same stepping. This order is set by the one read port of each memory and
// by the single scan unit. A finished result waits in the output register
// while the block goes back to idle; a stalled output only holds the block
// if a second result is ready before the first is taken. After reset a
// clearing pass writes every presence and summary word to zero, one word a
// cycle, and no item is accepted until it ends. Stored values are not
// cleared; their read data are used only for keys that are present.
module ordered_key_set_pred_succ #(
  parameter int KEY_BITS   = okspd_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = okspd_pkg::DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_op,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_found,
  output logic [KEY_BITS-1:0]   out_result_key,
  output logic [VALUE_BITS-1:0] out_result_value
);
  import okspd_pkg::*;

  localparam int W_IDX  = word_idx_bits(KEY_BITS);
  localparam int S_IDX  = sum_idx_bits(KEY_BITS);
  localparam int KX     = KEY_BITS + 11;
  localparam logic [W_IDX-1:0] W_LAST = W_IDX'(num_words(KEY_BITS) - 1);
  localparam logic [S_IDX-1:0] S_LAST = S_IDX'(num_sum_words(KEY_BITS) - 1);

  state_t                state_r, state_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic [W_IDX-1:0]      clr_idx_r, clr_idx_nxt;
  logic [S_IDX-1:0]      sw_cur_r, sw_cur_nxt;
  logic [W_IDX-1:0]      pw_idx_r, pw_idx_nxt;
  logic [KEY_BITS-1:0]   nkey_r, nkey_nxt;
  logic                  found_r, found_nxt;
  logic [KEY_BITS-1:0]   rkey_r, rkey_nxt;
  logic [VALUE_BITS-1:0] rval_r, rval_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [KEY_BITS-1:0]   out_key_r, out_key_nxt;
  logic [VALUE_BITS-1:0] out_value_r, out_value_nxt;

  // Memory interface.
  mem_ctl_t              ctl;
  logic [W_IDX-1:0]      pw_addr;
  logic [31:0]           pw_wdata, pw_rdata;
  logic [S_IDX-1:0]      sw_addr;
  logic [31:0]           sw_wdata, sw_rdata;
  logic [KEY_BITS-1:0]   val_addr;
  logic [VALUE_BITS-1:0] val_rdata;

  // Scan unit interface.
  logic [31:0]           scan_word;
  logic [4:0]            scan_pos;
  scan_mode_t            scan_mode;
  logic                  scan_hit;
  logic [4:0]            scan_idx;

  // Key fields: word index, bit in word, summary index, bit in summary.
  logic [KX-1:0]         in_x, k_x;
  logic [W_IDX-1:0]      in_w, k_w;
  logic [S_IDX-1:0]      in_sw, k_sw;
  logic [4:0]            k_b, k_sb;
  logic [31:0]           k_bit, k_sbit, pw_cleared;
  logic                  present, is_pred;

  // Keys and word indexes rebuilt from a base index and a scan result.
  logic [W_IDX-1:0]      word_base;
  logic [S_IDX-1:0]      sum_base;
  logic [KX-1:0]         key_from_word_x, word_from_sum_x;
  logic [KEY_BITS-1:0]   key_from_word;
  logic [W_IDX-1:0]      word_from_sum;
  logic                  at_edge;
  logic [S_IDX-1:0]      sw_step;

  assign in_x   = KX'(in_key);
  assign k_x    = KX'(key_r);
  assign in_w   = in_x[5 +: W_IDX];
  assign in_sw  = in_x[10 +: S_IDX];
  assign k_w    = k_x[5 +: W_IDX];
  assign k_sw   = k_x[10 +: S_IDX];
  assign k_b    = k_x[4:0];
  assign k_sb   = k_x[9:5];
  assign k_bit  = 32'd1 << k_b;
  assign k_sbit = 32'd1 << k_sb;
  assign present    = pw_rdata[k_b];
  assign pw_cleared = pw_rdata & ~k_bit;
  assign is_pred    = (op_r == OP_PRED);

  assign word_base       = (state_r == ST_RD) ? k_w : pw_idx_r;
  assign sum_base        = (state_r == ST_SUMK) ? k_sw : sw_cur_r;
  assign key_from_word_x = (KX'(word_base) << 5) | KX'(scan_idx);
  assign word_from_sum_x = (KX'(sum_base) << 5) | KX'(scan_idx);
  assign key_from_word   = key_from_word_x[KEY_BITS-1:0];
  assign word_from_sum   = word_from_sum_x[W_IDX-1:0];

  // The summary walk stops at the lowest word going down and at the
  // highest going up; otherwise it steps one summary word.
  assign at_edge = is_pred ? (sum_base == '0) : (sum_base == S_LAST);
  assign sw_step = is_pred ? S_IDX'(sum_base - 1'b1) : S_IDX'(sum_base + 1'b1);

  // Scan unit input selection by sequencer state.
  always_comb begin
    scan_word = pw_rdata;
    scan_pos  = k_b;
    scan_mode = is_pred ? SCAN_BELOW : SCAN_ABOVE;
    case (state_r)
      ST_SUMK: begin
        scan_word = sw_rdata;
        scan_pos  = k_sb;
      end
      ST_SUM: begin
        scan_word = sw_rdata;
        scan_mode = is_pred ? SCAN_TOP : SCAN_LOW;
      end
      ST_WRD: begin
        scan_mode = is_pred ? SCAN_TOP : SCAN_LOW;
      end
      default: begin
      end
    endcase
  end

  okspd_scan u_scan (
    .word (scan_word),
    .pos  (scan_pos),
    .mode (scan_mode),
    .hit  (scan_hit),
    .idx  (scan_idx)
  );

  okspd_store #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk       (clk),
    .ctl       (ctl),
    .pw_addr   (pw_addr),
    .pw_wdata  (pw_wdata),
    .pw_rdata  (pw_rdata),
    .sw_addr   (sw_addr),
    .sw_wdata  (sw_wdata),
    .sw_rdata  (sw_rdata),
    .val_addr  (val_addr),
    .val_wdata (value_r),
    .val_rdata (val_rdata)
  );

  // Sequencer: next state, memory requests and result capture.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    clr_idx_nxt   = clr_idx_r;
    sw_cur_nxt    = sw_cur_r;
    pw_idx_nxt    = pw_idx_r;
    nkey_nxt      = nkey_r;
    found_nxt     = found_r;
    rkey_nxt      = rkey_r;
    rval_nxt      = rval_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_key_nxt   = out_key_r;
    out_value_nxt = out_value_r;
    ctl           = '0;
    pw_addr       = k_w;
    pw_wdata      = pw_rdata | k_bit;
    sw_addr       = k_sw;
    sw_wdata      = sw_rdata | k_sbit;
    val_addr      = key_r;

    case (state_r)
      ST_CLR: begin
        ctl.pw_we = 1'b1;
        ctl.sw_we = 1'b1;
        pw_addr   = clr_idx_r;
        sw_addr   = clr_idx_r[S_IDX-1:0];
        pw_wdata  = '0;
        sw_wdata  = '0;
        if (clr_idx_r == W_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = W_IDX'(clr_idx_r + 1'b1);
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          // Read everything the key could need in one go.
          ctl.pw_re = 1'b1;
          ctl.sw_re = 1'b1;
          ctl.val_re = 1'b1;
          pw_addr   = in_w;
          sw_addr   = in_sw;
          val_addr  = in_key;
          op_nxt    = in_op;
          key_nxt   = in_key;
          value_nxt = in_value;
          state_nxt = ST_RD;
        end
      end

      ST_RD: begin
        found_nxt = 1'b0;
        rkey_nxt  = key_r;
        rval_nxt  = '0;
        state_nxt = ST_DONE;
        case (op_r)
          OP_INSERT: begin
            found_nxt  = present;
            rval_nxt   = present ? val_rdata : '0;
            ctl.pw_we  = 1'b1;
            ctl.sw_we  = 1'b1;
            ctl.val_we = 1'b1;
          end
          OP_LOOKUP: begin
            found_nxt = present;
            rval_nxt  = present ? val_rdata : '0;
          end
          OP_DELETE: begin
            found_nxt = present;
            rval_nxt  = present ? val_rdata : '0;
            pw_wdata  = pw_cleared;
            sw_wdata  = sw_rdata & ~k_sbit;
            ctl.pw_we = present;
            // The summary bit goes only when the word becomes empty.
            ctl.sw_we = present && (pw_cleared == '0);
          end
          OP_PRED, OP_SUCC: begin
            if (scan_hit) begin
              nkey_nxt   = key_from_word;
              val_addr   = key_from_word;
              ctl.val_re = 1'b1;
              state_nxt  = ST_VAL;
            end else begin
              state_nxt = ST_SUMK;
            end
          end
          default: begin
          end
        endcase
      end

      ST_SUMK, ST_SUM: begin
        if (scan_hit) begin
          pw_idx_nxt = word_from_sum;
          pw_addr    = word_from_sum;
          ctl.pw_re  = 1'b1;
          state_nxt  = ST_WRD;
        end else if (at_edge) begin
          state_nxt = ST_DONE;
        end else begin
          sw_cur_nxt = sw_step;
          sw_addr    = sw_step;
          ctl.sw_re  = 1'b1;
          state_nxt  = ST_SUM;
        end
      end

      ST_WRD: begin
        // The summary guarantees this word is nonzero.
        nkey_nxt   = key_from_word;
        val_addr   = key_from_word;
        ctl.val_re = 1'b1;
        state_nxt  = ST_VAL;
      end

      ST_VAL: begin
        found_nxt = 1'b1;
        rkey_nxt  = nkey_r;
        rval_nxt  = val_rdata;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_key_nxt   = rkey_r;
          out_value_nxt = rval_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    value_r     <= value_nxt;
    sw_cur_r    <= sw_cur_nxt;
    pw_idx_r    <= pw_idx_nxt;
    nkey_r      <= nkey_nxt;
    found_r     <= found_nxt;
    rkey_r      <= rkey_nxt;
    rval_r      <= rval_nxt;
    out_found_r <= out_found_nxt;
    out_key_r   <= out_key_nxt;
    out_value_r <= out_value_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_result_key   = out_key_r;
  assign out_result_value = out_value_r;

  // An accepted item always starts with the read cycle.
  `OKSPD_ASSERT(a_accept_reads, clk, rst_n, (in_valid && !in_stall) |=> (state_r == ST_RD), "accepted item did not start its read")
  // A word reached through the summary must have a key in it.
  `OKSPD_ASSERT(a_summary_word_nonzero, clk, rst_n, (state_r == ST_WRD) |-> (pw_rdata != '0), "summary points at an empty presence word")
  // The neighbor's value comes from a read issued the cycle before.
  `OKSPD_ASSERT(a_val_read_issued, clk, rst_n, (state_r == ST_VAL) |-> $past(ctl.val_re), "neighbor value used without a read")
  // A found neighbor lies strictly on the searched side of the key.
  `OKSPD_ASSERT(a_neighbor_side, clk, rst_n, (state_r == ST_VAL) |-> ((op_r == OP_PRED && nkey_r < key_r) || (op_r == OP_SUCC && nkey_r > key_r)), "neighbor on wrong side of key")
  // Presence words change only in the clearing pass or an update cycle.
  `OKSPD_ASSERT(a_pw_write_states, clk, rst_n, ctl.pw_we |-> (state_r == ST_CLR || state_r == ST_RD), "presence write outside update")

endmodule
